// File: design/esl_pkg.sv
// Shared types and constants for the encoder speed low-pass block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package esl_pkg;

    localparam int CNT_W   = 32;
    localparam int DT_W    = 20;
    localparam int PPR_W   = 16;
    localparam int ALPHA_W = 17;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // 60e6 us per minute times ten for the tenths of a pulse.
    localparam logic [29:0] RPM_NUMERATOR    = 30'd600000000;
    // 2*pi/60 in unsigned Q0.32.
    localparam logic [28:0] RADS_PER_RPM_Q32 = 29'd449767923;

    localparam logic [PPR_W-1:0]   PPR_RESET   = 16'd4488;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd11796;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [0:0] {
        REG_PPR   = 1'b0,
        REG_ALPHA = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_RAW,
        ST_FILT,
        ST_UPDATE,
        ST_RADS,
        ST_OUT
    } esl_state_t;

    typedef struct packed {
        logic start;
        logic prep;
        logic check;
        logic div_step;
        logic raw;
        logic filt_mul;
        logic filt_update;
        logic rads_mul;
        logic load_out;
    } esl_cmd_t;

    typedef struct packed {
        logic zero_dt;
        logic div_last;
        logic out_free;
    } esl_status_t;

    typedef struct packed {
        logic [PPR_W-1:0]   ppr;
        logic [ALPHA_W-1:0] alpha;
    } esl_cfg_t;

endpackage

// File: design/esl_if.sv
// Stream interfaces for the sample and result channels of the block.
// Depends on esl_pkg for the field widths.
`timescale 1ns / 1ps

interface esl_sample_if;
    import esl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CNT_W-1:0] encoder_count;
    logic [DT_W-1:0]         elapsed_us;

    modport source (output valid, output encoder_count, output elapsed_us, input ready);
    modport sink   (input valid, input encoder_count, input elapsed_us, output ready);
endinterface

interface esl_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed_rpm_q8;
    logic signed [31:0] speed_rads_q8;
    logic               time_error;

    modport source (output valid, output speed_rpm_q8, output speed_rads_q8,
                    output time_error, input ready);
    modport sink   (input valid, input speed_rpm_q8, input speed_rads_q8,
                    input time_error, output ready);
endinterface

// File: design/esl_cfg.sv
// APB-style configuration registers: pulses per revolution and filter weight.
// Depends on esl_pkg.
`timescale 1ns / 1ps

module esl_cfg
    import esl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output esl_cfg_t          cfg
);

    logic [PPR_W-1:0]   ppr_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    reg_index_t         index;
    logic               wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg   <= PPR_RESET;
            alpha_reg <= ALPHA_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PPR:   ppr_reg   <= pwdata[PPR_W-1:0];
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                default:   ppr_reg   <= ppr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PPR:   prdata = {{(DATA_W-PPR_W){1'b0}}, ppr_reg};
            REG_ALPHA: prdata = {{(DATA_W-ALPHA_W){1'b0}}, alpha_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.ppr   = ppr_reg;
    assign cfg.alpha = alpha_reg;

endmodule

// File: design/esl_ctrl.sv
// Sequencer for the speed calculation: steps the datapath through delta,
// division, filter and output phases. Depends on esl_pkg.
`timescale 1ns / 1ps

module esl_ctrl
    import esl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        in_ready,
    input  esl_status_t sts,
    output esl_cmd_t    cmd
);

    esl_state_t state_reg;
    esl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:   state_next = sts.zero_dt ? ST_RADS : ST_CHECK;
            ST_CHECK:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_RAW;
            end
            ST_RAW:    state_next = ST_FILT;
            ST_FILT:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RADS;
            ST_RADS:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = sample_valid;
            end
            ST_PREP:   cmd.prep        = 1'b1;
            ST_CHECK:  cmd.check       = 1'b1;
            ST_DIV:    cmd.div_step    = 1'b1;
            ST_RAW:    cmd.raw         = 1'b1;
            ST_FILT:   cmd.filt_mul    = 1'b1;
            ST_UPDATE: cmd.filt_update = 1'b1;
            ST_RADS:   cmd.rads_mul    = 1'b1;
            ST_OUT:    cmd.load_out    = sts.out_free;
            default:   cmd             = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start a calculation");

    a_no_update_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> !sts.zero_dt)
        else $error("filter updated for a zero elapsed time");

    a_div_then_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_RAW))
        else $error("division did not hand over to the raw speed phase");
`endif

endmodule

// File: design/esl_datapath.sv
// Datapath: count delta, restoring divider for the raw rpm, low-pass filter,
// rad/s scaling and the result register. Depends on esl_pkg and esl_if.
`timescale 1ns / 1ps

module esl_datapath
    import esl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [CNT_W-1:0] encoder_count,
    input  logic [DT_W-1:0]         elapsed_us,
    input  esl_cfg_t                cfg,
    input  esl_cmd_t                cmd,
    output esl_status_t             sts,
    esl_result_if.source            result
);

    localparam int DEN_W = PPR_W + DT_W;
    localparam int NUM_W = CNT_W + 30;

    // Filter and count state.
    logic [CNT_W-1:0]        prev_count_reg;
    logic signed [31:0]      filt_reg;

    // Per-sample working registers.
    logic [CNT_W-1:0]        delta_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    neg_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    ovf_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [31:0]             low_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic signed [31:0]      raw_reg;
    logic signed [50:0]      fprod_reg;
    logic signed [61:0]      rprod_reg;

    // Result register.
    logic                    res_valid_reg;
    logic signed [31:0]      res_rpm_reg;
    logic signed [31:0]      res_rads_reg;
    logic                    res_err_reg;

    logic [CNT_W-1:0]        mag;
    logic [PPR_W-1:0]        ppr_eff;
    logic [ALPHA_W-1:0]      alpha_eff;
    logic [NUM_W-25:0]       num_hi;
    logic [DEN_W:0]          trial;
    logic                    q_bit;
    logic [31:0]             limit;
    logic [31:0]             total;
    logic signed [32:0]      diff;
    logic signed [17:0]      alpha_s;
    logic signed [50:0]      fround;
    logic signed [34:0]      fstep;
    logic signed [34:0]      filt_new;
    logic signed [63:0]      rads_sum;

    assign mag       = delta_reg[CNT_W-1] ? (~delta_reg + 1'b1) : delta_reg;
    assign ppr_eff   = (cfg.ppr == '0) ? {{(PPR_W-1){1'b0}}, 1'b1} : cfg.ppr;
    assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

    // The dividend is num * 256; its part above the 32 quotient bits.
    assign num_hi = num_reg[NUM_W-1:24];
    assign trial  = {rem_reg, low_reg[31]};
    assign q_bit  = (trial >= {1'b0, den_reg});

    assign limit = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign total = (ovf_reg || (low_reg > limit)) ? limit : low_reg;

    assign diff     = {raw_reg[31], raw_reg} - {filt_reg[31], filt_reg};
    assign alpha_s  = $signed({1'b0, alpha_eff});
    assign fround   = fprod_reg + 51'sd32768;
    assign fstep    = fround[50:16];
    assign filt_new = {{3{filt_reg[31]}}, filt_reg} + fstep;
    assign rads_sum = {{2{rprod_reg[61]}}, rprod_reg} + 64'sd2147483648;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            filt_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
                prev_count_reg <= encoder_count;
            if (cmd.filt_update)
                filt_reg <= filt_new[31:0];
            if (cmd.load_out)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            delta_reg <= encoder_count - prev_count_reg;
            dt_reg    <= elapsed_us;
        end
        if (cmd.prep)
        begin
            neg_reg <= delta_reg[CNT_W-1];
            num_reg <= NUM_W'(mag) * NUM_W'(RPM_NUMERATOR);
            den_reg <= DEN_W'(ppr_eff) * DEN_W'(dt_reg);
        end
        if (cmd.check)
        begin
            // A quotient of 2^32 or more saturates whatever the steps give.
            ovf_reg     <= (num_hi >= {2'b00, den_reg});
            rem_reg     <= num_hi[DEN_W-1:0];
            low_reg     <= {num_reg[23:0], 8'h00};
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg     <= q_bit ? (trial[DEN_W-1:0] - den_reg) : trial[DEN_W-1:0];
            low_reg     <= {low_reg[30:0], q_bit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.raw)
            raw_reg <= neg_reg ? $signed(~total + 1'b1) : $signed(total);
        if (cmd.filt_mul)
            fprod_reg <= 51'(diff) * 51'(alpha_s);
        if (cmd.rads_mul)
            rprod_reg <= 62'(filt_reg) * 62'($signed({1'b0, RADS_PER_RPM_Q32}));
        if (cmd.load_out)
        begin
            res_rpm_reg  <= filt_reg;
            res_rads_reg <= rads_sum[63:32];
            res_err_reg  <= (dt_reg == '0);
        end
    end

    assign sts.zero_dt  = (dt_reg == '0);
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !res_valid_reg || result.ready;

    assign result.valid         = res_valid_reg;
    assign result.speed_rpm_q8  = res_rpm_reg;
    assign result.speed_rads_q8 = res_rads_reg;
    assign result.time_error    = res_err_reg;

`ifndef NO_ASSERTIONS
    a_filter_held: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.filt_update |=> $stable(filt_reg))
        else $error("filter state changed outside its update phase");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> res_valid_reg)
        else $error("result load did not raise valid");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!res_valid_reg || result.ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// File: design/encoder_speed_lowpass.sv
// Encoder speed with first-order low-pass: top level.
// Each sample beat carries encoder_count and elapsed_us; each yields one result
// beat with the filtered speed in rpm and rad/s (signed Q8) and time_error.
// On the normal path an item steps from acceptance to result load through the
// prepare, check, restoring-divide (32 steps, one quotient bit per cycle, forming
// the raw rpm), raw, filter, update, rad/s and output states; a zero elapsed time
// goes from prepare straight to rad/s and output, skipping division and filter.
// sample.ready is high while the sequencer is idle; the result sits in an
// output register, so the next sample is taken while it waits.
// If the receiver stalls, the finished result holds; a following calculation
// then waits at its final step until the register is free.
// Reset clears the stored count and filtered speed to zero and loads the
// register defaults (4488 tenths of a pulse, alpha 11796 in Q1.16).
// Registers at byte addresses 0 (pulses per rev) and 4 (alpha); write
// only while no sample is in flight. pready is always high.
// Depends on esl_pkg, esl_if, esl_cfg, esl_ctrl and esl_datapath.
`timescale 1ns / 1ps

module encoder_speed_lowpass
    import esl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    esl_sample_if.sink        sample,
    esl_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    esl_cfg_t    cfg;
    esl_cmd_t    cmd;
    esl_status_t sts;
    logic        in_ready;

    assign sample.ready = in_ready;

    esl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    esl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .in_ready     (in_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    esl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .encoder_count (sample.encoder_count),
        .elapsed_us    (sample.elapsed_us),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result)
    );

endmodule

// File: tb/sv/encoder_speed_lowpass_tb.sv
// Self-checking testbench for encoder_speed_lowpass: drives sample beats and register
// writes, predicts each filtered speed result and compares it with the result beats.
// Depends on esl_pkg, the esl_if interfaces and the encoder_speed_lowpass RTL.
`timescale 1ns / 1ps

module encoder_speed_lowpass_tb;
    import esl_pkg::*;

    localparam int          HALF_PERIOD     = 6;
    localparam int          DRAIN_CYCLES    = 50;
    localparam int          HOLD_CYCLES     = 600;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          RANDOM_PHASES   = 6;
    localparam int          ITEMS_PER_PHASE = 260;
    localparam logic [63:0] US_TENTHS_PER_MIN = 64'd600000000;
    localparam longint      RADS_PER_RPM    = 449767923;
    localparam logic [16:0] ALPHA_UNITY     = 17'd65536;

    typedef struct {
        logic signed [31:0] rpm;
        logic signed [31:0] rads;
        logic               err;
    } speed_beat_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    esl_sample_if samples ();
    esl_result_if speeds ();

    // Predictor state and register copies.
    logic [31:0]        seen_count;
    logic signed [31:0] filt_rpm_q8;
    logic [15:0]        ppr_reg;
    logic [16:0]        alpha_reg;

    speed_beat_t        expected_speeds[$];
    logic [31:0]        stim_count;
    int unsigned        mismatches;
    int unsigned        quiet_cycles;
    int unsigned        src_idle_pct;
    int unsigned        sink_idle_pct;
    bit                 hold_req;
    int unsigned        hold_left;

    encoder_speed_lowpass dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (samples),
        .result  (speeds),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic longint raw_rpm_q8(input logic [31:0] delta, input logic [19:0] dt);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] total;
        neg = delta[31];
        mag = neg ? {32'd0, (~delta) + 32'd1} : {32'd0, delta};
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        den = 64'(ppr_reg == 16'd0 ? 16'd1 : ppr_reg) * 64'(dt);
        num = mag * US_TENTHS_PER_MIN;
        quo = num / den;
        rem = num % den;
        if (mag == 64'd0)
            total = 64'd0;
        else if (quo > (lim >> 8))
            total = lim;
        else
        begin
            total = (quo << 8) + (rem << 8) / den;
            if (total > lim)
                total = lim;
        end
        return neg ? -longint'(total) : longint'(total);
    endfunction

    // Advances the predictor by one sample and returns the result it should produce.
    function automatic speed_beat_t predict_speed(input logic [31:0] cnt, input logic [19:0] dt);
        speed_beat_t beat;
        logic [31:0] delta;
        longint      filt;
        longint      raw;
        longint      gain;
        delta      = cnt - seen_count;
        seen_count = cnt;
        filt       = longint'(filt_rpm_q8);
        beat.err   = (dt == 20'd0);
        if (!beat.err)
        begin
            raw  = raw_rpm_q8(delta, dt);
            gain = (alpha_reg > ALPHA_UNITY) ? longint'(ALPHA_UNITY) : longint'(alpha_reg);
            // Round half up: add half an LSB, then floor with an arithmetic shift.
            filt = filt + (((raw - filt) * gain + 64'sd32768) >>> 16);
            filt_rpm_q8 = 32'(filt);
        end
        beat.rpm  = 32'(filt);
        beat.rads = 32'((filt * RADS_PER_RPM + (64'sd1 <<< 31)) >>> 32);
        return beat;
    endfunction

    task automatic send_sample(input logic [31:0] cnt, input logic [19:0] dt);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            samples.valid <= 1'b0;
            repeat ($urandom_range(45, 1)) @(posedge clk);
        end
        samples.valid         <= 1'b1;
        samples.encoder_count <= cnt;
        samples.elapsed_us    <= dt;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        expected_speeds.push_back(predict_speed(cnt, dt));
        stim_count = cnt;
    endtask

    // Mostly plausible motion with random content; the rest is noise and edge values.
    task automatic send_random_sample();
        int unsigned pick;
        logic [31:0] cnt;
        logic [19:0] dt;
        pick = $urandom_range(99);
        cnt  = stim_count + 32'(int'($urandom_range(4000)) - 2000);
        dt   = 20'($urandom_range(20000, 50));
        if (pick < 55)
            ;
        else if (pick < 70)
            cnt = $urandom();
        else if (pick < 78)
            dt = 20'd0;
        else if (pick < 86)
        begin
            case ($urandom_range(3))
                0: dt = 20'd1;
                1: dt = 20'hFFFFF;
                2: dt = 20'd1000000;
                default: dt = 20'($urandom_range(8, 1));
            endcase
        end
        else if (pick < 92)
        begin
            cnt = stim_count + 32'($urandom_range(1 << 24));
            dt  = 20'($urandom_range(16, 1));
        end
        else
        begin
            cnt = $urandom();
            dt  = 20'($urandom());
        end
        send_sample(cnt, dt);
    endtask

    task automatic wait_drained();
        samples.valid <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PPR:   ppr_reg   = val[15:0];
            REG_ALPHA: alpha_reg = val[16:0];
            default:   ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] ppr, input logic [31:0] alpha);
        wait_drained();
        write_reg(REG_PPR, ppr);
        write_reg(REG_ALPHA, alpha);
    endtask

    task automatic test_directed_speeds();
        send_sample(32'd0, 20'd1000);
        send_sample(32'd100, 20'd1000);
        send_sample(32'd50, 20'd1000);
        // Zero elapsed time, once with the count unchanged and once with it moved.
        send_sample(32'd50, 20'd0);
        send_sample(32'd1000, 20'd0);
        send_sample(32'd2010, 20'd1);
        send_sample(32'd2010 - 32'd100000, 20'd1);
        send_sample(32'h7FFF_FFFF, 20'd1000000);
        send_sample(32'h8000_0000, 20'd1000000);
        send_sample(32'd0, 20'hFFFFF);
        send_sample(32'd1, 20'd1000000);
        send_sample(32'hFFFF_FFFF, 20'd500);
        send_sample($urandom(), 20'hFFFFF);
    endtask

    task automatic test_register_extremes();
        // A pulse count of zero behaves as one.
        set_config(32'd0, 32'd65536);
        send_sample(stim_count + 32'd5, 20'd1000);
        send_sample(stim_count - 32'd5, 20'd7);
        set_config(32'd65535, 32'd1);
        send_sample(stim_count + 32'd300, 20'd100);
        send_sample(stim_count - 32'd40, 20'd2);
        // Alpha of zero holds the filter; above one it saturates to one.
        set_config(32'd4488, 32'd0);
        send_sample(stim_count + 32'd900, 20'd50);
        send_sample(stim_count - 32'd900, 20'd50);
        set_config(32'd4488, 32'd131071);
        send_sample(stim_count + 32'd77, 20'd1000);
        send_sample(stim_count + 32'd12, 20'd333);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(32'd4488, 32'd11796);
                1: set_config(32'd1, 32'd65536);
                2: set_config(32'd65535, 32'd1);
                default: set_config($urandom_range(65535), $urandom_range(131071));
            endcase
            repeat (ITEMS_PER_PHASE) send_random_sample();
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_output_holdoff();
        set_config(32'd4488, 32'd11796);
        src_idle_pct = 0;
        hold_req = 1'b1;
        repeat (20) send_random_sample();
        src_idle_pct = 24;
    endtask

    task automatic test_no_idle_stretch();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (200) send_random_sample();
        src_idle_pct  = 24;
        sink_idle_pct = 24;
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            speeds.ready <= 1'b0;
        end
        else
            speeds.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        speed_beat_t want;
        if (rst_n && speeds.valid && speeds.ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = expected_speeds.pop_front();
                if (speeds.speed_rpm_q8 !== want.rpm)
                begin
                    $error("speed_rpm_q8: expected %0d, got %0d", want.rpm, speeds.speed_rpm_q8);
                    mismatches++;
                end
                if (speeds.speed_rads_q8 !== want.rads)
                begin
                    $error("speed_rads_q8: expected %0d, got %0d",
                           want.rads, speeds.speed_rads_q8);
                    mismatches++;
                end
                if (speeds.time_error !== want.err)
                begin
                    $error("time_error: expected %0b, got %0b", want.err, speeds.time_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (samples.valid && samples.ready) || (speeds.valid && speeds.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("encoder_speed_lowpass_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        samples.valid         = 1'b0;
        samples.encoder_count = '0;
        samples.elapsed_us    = '0;
        speeds.ready          = 1'b0;
        seen_count            = 32'd0;
        filt_rpm_q8           = 32'sd0;
        ppr_reg               = 16'd4488;
        alpha_reg             = 17'd11796;
        stim_count            = 32'd0;
        mismatches            = 0;
        quiet_cycles          = 0;
        src_idle_pct          = 24;
        sink_idle_pct         = 24;
        hold_req              = 1'b0;
        hold_left             = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_speeds();
        test_register_extremes();
        test_random_traffic();
        test_output_holdoff();
        test_no_idle_stretch();
        wait_drained();

        if (mismatches == 0)
            $display("encoder_speed_lowpass_tb: done, clean");
        else
            $display("encoder_speed_lowpass_tb: done, errors");
        $finish;
    end

endmodule
